### rtl/edq_pkg.sv
package edq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_WIDTH  = 32;
  localparam int CNT_W       = 5;
  localparam int IDX_W       = 4;

  localparam logic [2:0] OP_ENQ     = 3'd0;
  localparam logic [2:0] OP_DEQ_DST = 3'd1;
  localparam logic [2:0] OP_DEQ_OLD = 3'd2;
  localparam logic [2:0] OP_DROP    = 3'd3;
  localparam logic [2:0] OP_FIND    = 3'd4;
  localparam logic [2:0] OP_SIZE    = 3'd5;

  localparam logic REG_MAX_ENTRIES = 1'b0;
  localparam logic REG_EXPIRY_BASE = 1'b1;

  typedef struct packed {
    logic [7:0]            msg_type;
    logic [7:0]            key_first;
    logic [7:0]            key_second;
    logic [7:0]            destination;
    logic [15:0]           handle;
    logic [TIME_WIDTH-1:0] expiry;
  } entry_t;

endpackage

### rtl/edq_cell.sv
module edq_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic            load,
  input  edq_pkg::entry_t load_entry,
  input  edq_pkg::entry_t from_next,
  input  logic            valid_next,
  output edq_pkg::entry_t entry,
  output logic            valid
);

  // Each cell holds one slot; compaction moves entries one cell toward the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      entry <= load_entry;
    end else if (shift) begin
      valid <= valid_next;
      entry <= from_next;
    end
  end

endmodule

### rtl/expiring_dedup_request_queue_core.sv
// Expiring, duplicate-suppressing request queue.
// Request channel: in_valid / in_stall with fields op, now_time, msg_type,
// key_first, key_second, destination, lifetime, entry_handle. Result channel:
// out_valid / out_stall with ok, out_* entry fields and queue_size.
// One request is worked at a time. The queue is a row of 16 cells; a removal
// shifts the tail one cell toward the head. A request first purges expired
// entries, then scans the rest (find skips the purge; size, dequeue-oldest and
// dequeue-destination after a hit stop early); an enqueue without a duplicate
// then evicts from the head while the queue is at capacity and appends, and the
// result is registered. An unused op code goes straight to the result step.
// in_stall is high from the cycle after acceptance until the result is
// registered, so no new request is taken before the last one is through.
// A stall on the result side holds the result register; a request taken
// meanwhile is worked and waits in its last step until the result ahead of it
// is delivered.
// Reset empties the queue at once (valid bits and count), sets max_entries to
// 16 and expiry_base to 0. Registers: max_entries at 0x0, expiry_base at 0x4.
module expiring_dedup_request_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [31:0] now_time,
  input  logic [7:0]  msg_type,
  input  logic [7:0]  key_first,
  input  logic [7:0]  key_second,
  input  logic [7:0]  destination,
  input  logic [31:0] lifetime,
  input  logic [15:0] entry_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [7:0]  out_type,
  output logic [7:0]  out_key_first,
  output logic [7:0]  out_key_second,
  output logic [7:0]  out_destination,
  output logic [15:0] out_handle,
  output logic [31:0] out_expiry,
  output logic [4:0]  queue_size
);

  localparam int D  = edq_pkg::QUEUE_DEPTH;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PURGE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [4:0]  max_entries;
  logic [31:0] expiry_base;

  // Configuration writes.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 5'd16;
      expiry_base <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        edq_pkg::REG_MAX_ENTRIES: max_entries <= pwdata[4:0];
        edq_pkg::REG_EXPIRY_BASE: expiry_base <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      edq_pkg::REG_MAX_ENTRIES: prdata = {27'd0, max_entries};
      edq_pkg::REG_EXPIRY_BASE: prdata = expiry_base;
      default:                  prdata = '0;
    endcase
  end

  // Cell row.
  edq_pkg::entry_t cell_entry [D];
  logic [D-1:0]    cell_valid;
  logic [D-1:0]    shift_en;
  logic [D-1:0]    load_en;
  edq_pkg::entry_t new_entry;

  logic [2:0]  state;
  logic [2:0]  op_r;
  logic [31:0] now_r;
  logic [7:0]  dst_r;
  logic [7:0]  type_r, k1_r, k2_r;
  logic [15:0] hnd_r;
  logic [31:0] life_r;
  logic [4:0]  pos;      // scan position
  logic [4:0]  count;
  logic        hit;      // duplicate seen, or found, or dequeued
  edq_pkg::entry_t taken;

  // Scan inspects the cell at pos; a removal shifts cells pos.. toward the head.
  logic [3:0]      idx;
  edq_pkg::entry_t cur;
  logic            cur_valid;
  logic            remove;
  logic [4:0]      cap;
  logic [32:0]     exp_sum;

  assign idx       = pos[3:0];
  assign cur       = cell_entry[idx];
  assign cur_valid = pos < count;
  assign cap       = (max_entries == 5'd0) ? 5'd1 :
                     (max_entries > 5'd16) ? 5'd16 : max_entries;
  assign exp_sum   = {1'b0, expiry_base} + {1'b0, life_r};

  always_comb begin
    remove = 1'b0;
    if (cur_valid) begin
      if (state == S_PURGE) begin
        remove = cur.expiry < now_r;
      end else if (state == S_SCAN) begin
        case (op_r)
          edq_pkg::OP_DEQ_DST: remove = !hit && cur.destination == dst_r;
          edq_pkg::OP_DEQ_OLD: remove = !hit && pos == 5'd0;
          edq_pkg::OP_DROP:    remove = cur.destination == dst_r;
          default:             remove = 1'b0;
        endcase
      end else if (state == S_EVICT) begin
        remove = !hit && count >= cap;
      end
    end
  end

  always_comb begin
    new_entry.msg_type    = type_r;
    new_entry.key_first   = k1_r;
    new_entry.key_second  = k2_r;
    new_entry.destination = dst_r;
    new_entry.handle      = hnd_r;
    new_entry.expiry      = exp_sum[32] ? '1 : exp_sum[31:0];
  end

  for (genvar g = 0; g < D; g++) begin : g_cell
    assign shift_en[g] = remove && (5'(g) >= pos);
    assign load_en[g]  = (state == S_EVICT) && !remove && !hit && (count == 5'(g));
    if (g < D - 1) begin : g_mid
      edq_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift_en[g]), .load(load_en[g]),
        .load_entry(new_entry), .from_next(cell_entry[g+1]),
        .valid_next(cell_valid[g+1]), .entry(cell_entry[g]), .valid(cell_valid[g])
      );
    end else begin : g_last
      edq_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift_en[g]), .load(load_en[g]),
        .load_entry(new_entry), .from_next(cell_entry[g]),
        .valid_next(1'b0), .entry(cell_entry[g]), .valid(cell_valid[g])
      );
    end
  end

  assign in_stall = state != S_IDLE;

  // Sequencer: purge, scan, then enqueue eviction and append.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= op;
            now_r  <= now_time;
            dst_r  <= destination;
            type_r <= msg_type;
            k1_r   <= key_first;
            k2_r   <= key_second;
            hnd_r  <= entry_handle;
            life_r <= lifetime;
            pos    <= '0;
            hit    <= 1'b0;
            taken  <= '0;
            if (op == edq_pkg::OP_FIND) state <= S_SCAN;
            else if (op > edq_pkg::OP_SIZE) state <= S_DONE;
            else state <= S_PURGE;
          end
        end
        S_PURGE: begin
          if (!cur_valid) begin
            pos   <= '0;
            state <= S_SCAN;
          end else if (remove) begin
            count <= count - 5'd1;
          end else begin
            pos <= pos + 5'd1;
          end
        end
        S_SCAN: begin
          if (!cur_valid || op_r == edq_pkg::OP_SIZE ||
              (op_r == edq_pkg::OP_DEQ_DST && hit) ||
              (op_r == edq_pkg::OP_DEQ_OLD && pos != 5'd0)) begin
            pos   <= '0;
            state <= (op_r == edq_pkg::OP_ENQ) ? S_EVICT : S_DONE;
          end else if (remove) begin
            count <= count - 5'd1;
            if (op_r != edq_pkg::OP_DROP) begin
              hit   <= 1'b1;
              taken <= cur;
            end
          end else begin
            if (op_r == edq_pkg::OP_ENQ && cur.msg_type == type_r &&
                cur.key_first == k1_r && cur.key_second == k2_r) hit <= 1'b1;
            if (op_r == edq_pkg::OP_FIND && cur.destination == dst_r) hit <= 1'b1;
            if (op_r == edq_pkg::OP_DEQ_OLD) pos <= 5'd1;
            else pos <= pos + 5'd1;
          end
        end
        S_EVICT: begin
          pos <= '0;
          if (hit) begin
            state <= S_DONE;
          end else if (remove) begin
            count <= count - 5'd1;
          end else begin
            count <= count + 5'd1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            queue_size      <= count;
            out_type        <= taken.msg_type;
            out_key_first   <= taken.key_first;
            out_key_second  <= taken.key_second;
            out_destination <= taken.destination;
            out_handle      <= taken.handle;
            out_expiry      <= taken.expiry;
            case (op_r) inside
              edq_pkg::OP_ENQ:  ok <= !hit;
              edq_pkg::OP_DROP: ok <= 1'b1;
              edq_pkg::OP_SIZE: ok <= 1'b1;
              edq_pkg::OP_DEQ_DST, edq_pkg::OP_DEQ_OLD, edq_pkg::OP_FIND: ok <= hit;
              default:          ok <= 1'b0;
            endcase
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
    end
  end

  // Count never exceeds depth and matches the valid cells; no request is taken while busy.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 5'd16) else $error("entry count beyond depth");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("request taken while busy");
  a_dup_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT && hit) |=> $stable(count)) else $error("duplicate changed count");
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count)) else $error("valid cells differ from count");

endmodule
